// ===== design/pdp_pkg.sv =====
// Package: shared types, constants and register map of the depth projection block.
`timescale 1ns / 1ps
package pdp_pkg;

    localparam int unsigned IMAGE_WIDTH_DEF  = 640;
    localparam int unsigned IMAGE_HEIGHT_DEF = 480;

    localparam int unsigned DEPTH_W = 31;   // stored depth, unsigned Q15.16
    localparam int unsigned PROD_W  = 64;   // focal * coordinate
    localparam int unsigned DIVD_W  = 62;   // magnitude of the product
    localparam int unsigned PIX_W   = 48;   // pixel coordinate before range check
    localparam int unsigned CNT_W   = 6;    // divider step counter

    localparam logic [DEPTH_W-1:0] RESET_MAX_DEPTH = 31'd655360;

    localparam logic [2:0] STATUS_WRITTEN = 3'd0;
    localparam logic [2:0] STATUS_KEPT    = 3'd1;
    localparam logic [2:0] STATUS_RANGE   = 3'd2;
    localparam logic [2:0] STATUS_OFF     = 3'd3;
    localparam logic [2:0] STATUS_READ    = 3'd4;

    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_MIN_D    = 3'd4;
    localparam logic [2:0] REG_MAX_D    = 3'd5;
    localparam logic [2:0] REG_ACT_W    = 3'd6;
    localparam logic [2:0] REG_ACT_H    = 3'd7;

    typedef struct packed {
        logic [30:0]        focal_x;
        logic [30:0]        focal_y;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        min_depth;
        logic [30:0]        max_depth;
        logic [9:0]         active_width;
        logic [8:0]         active_height;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIVS,
        S_DIVX,
        S_DIVY,
        S_SUM,
        S_PIX,
        S_CHK,
        S_MRD,
        S_MUPD,
        S_OUT
    } t_state;

endpackage

// ===== design/point_depth_projection.sv =====
// Top level: pinhole projection of points into a z-buffered depth image.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: x, y, z, col, row; tuser: req_type
//  m_axis    out  tvalid/tready             tdata: depth_value; tuser: status
//  apb       in   psel/penable/pready       8 registers at 4*i
//
// A point is projected with the shared divider, which runs 62 steps for the column
// and then 62 for the row. A pixel read uses the read-modify-write of the depth
// store.
// After reset a clearing pass writes IMAGE_WIDTH*IMAGE_HEIGHT entries, one a
// cycle, before the first beat is taken; register writes are taken throughout.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps
module point_depth_projection #(
    parameter int unsigned IMAGE_WIDTH  = pdp_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = pdp_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [119:0]   s_axis_tdata,  // x[31:0] y[63:32] z[95:64] col[105:96] row[114:106]
    input  logic           s_axis_tuser,  // req_type
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [31:0]    m_axis_tdata,  // depth_value[30:0]
    output logic [2:0]     m_axis_tuser,  // status
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import pdp_pkg::*;

    localparam int unsigned ENTRIES = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_cfg   cfg;
    t_state r_state, n_state;

    logic                     r_req;
    logic signed [31:0]       r_x, r_y, r_z;
    logic signed [PROD_W-1:0] r_px, r_py, r_qx, r_qy, r_sx, r_sy;
    logic                     r_negy;
    logic signed [PIX_W-1:0]  r_cx, r_cy;
    logic [AW-1:0]            r_addr, r_clr;
    logic [2:0]               r_rstat;
    logic [DEPTH_W-1:0]       r_rdep;
    logic                     r_ovalid;
    logic [2:0]               r_ostat;
    logic [DEPTH_W-1:0]       r_odep;

    logic                     accept, out_load, z_bad, on_img;
    logic                     div_start, div_done;
    logic [DIVD_W-1:0]        div_in, div_q;
    logic signed [PROD_W-1:0] qx_signed;
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr;
    logic [DEPTH_W-1:0]       mem_wdata, mem_rdata;
    logic                     upd_write;
    logic signed [PROD_W-1:0] sum_x, sum_y;

    pdp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pdp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (r_z[DEPTH_W-1:0]),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    pdp_depth_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_odep};
    assign m_axis_tuser  = r_ostat;

    assign z_bad = (r_z <= 32'sd0) || (r_z > $signed({1'b0, cfg.max_depth}))
                || (r_z < $signed({1'b0, cfg.min_depth}));

    assign on_img = (r_cx >= 0) && (r_cy >= 0)
                 && (r_cx < $signed({1'b0, PIX_W'(cfg.active_width)}))
                 && (r_cx < $signed({1'b0, PIX_W'(IMAGE_WIDTH)}))
                 && (r_cy < $signed({1'b0, PIX_W'(cfg.active_height)}))
                 && (r_cy < $signed({1'b0, PIX_W'(IMAGE_HEIGHT)}));

    // signs of the products are kept beside the divider and put back on its magnitudes
    assign qx_signed = r_px[PROD_W-1] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    assign upd_write = r_req || (r_z[DEPTH_W-1:0] < mem_rdata);
    assign sum_x = r_qx + PROD_W'(cfg.center_x) + PROD_W'(32768);
    assign sum_y = r_qy + PROD_W'(cfg.center_y) + PROD_W'(32768);

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_in    = r_px[PROD_W-1] ? DIVD_W'(-r_px) : DIVD_W'(r_px);
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_req ? cfg.max_depth : r_z[DEPTH_W-1:0];
        out_load  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = RESET_MAX_DEPTH;
                if (r_clr == AW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_req) begin
                    n_state = S_CHK;
                end else if (z_bad) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_DIVS;
            S_DIVS: begin
                div_start = 1'b1;
                n_state   = S_DIVX;
            end
            S_DIVX: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_in    = r_py[PROD_W-1] ? DIVD_W'(-r_py) : DIVD_W'(r_py);
                    n_state   = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: n_state = S_PIX;
            S_PIX: n_state = S_CHK;
            S_CHK: n_state = on_img ? S_MRD : S_OUT;
            S_MRD: begin
                mem_re  = 1'b1;
                n_state = S_MUPD;
            end
            S_MUPD: begin
                mem_we  = upd_write;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ostat <= r_rstat;
            r_odep  <= r_rdep;
        end
        unique case (r_state)
            S_IDLE: begin
                r_req <= s_axis_tuser;
                r_x   <= s_axis_tdata[31:0];
                r_y   <= s_axis_tdata[63:32];
                r_z   <= s_axis_tdata[95:64];
                r_cx  <= PIX_W'(s_axis_tdata[105:96]);
                r_cy  <= PIX_W'(s_axis_tdata[114:106]);
            end
            S_DECODE: begin
                r_rstat <= STATUS_RANGE;
                r_rdep  <= '0;
            end
            S_MUL: begin
                r_px <= $signed({1'b0, cfg.focal_x}) * r_x;
                r_py <= $signed({1'b0, cfg.focal_y}) * r_y;
            end
            S_DIVX: begin
                if (div_done) begin
                    r_qx   <= qx_signed;
                    r_negy <= r_py[PROD_W-1];
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    r_qy <= r_negy ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
                end
            end
            S_SUM: begin
                r_sx <= sum_x;
                r_sy <= sum_y;
            end
            S_PIX: begin
                // divide by 65536 rounding toward zero
                r_cx <= PIX_W'((r_sx < 0 ? r_sx + PROD_W'(65535) : r_sx) >>> 16);
                r_cy <= PIX_W'((r_sy < 0 ? r_sy + PROD_W'(65535) : r_sy) >>> 16);
            end
            S_CHK: begin
                r_rstat <= STATUS_OFF;
                r_rdep  <= '0;
                r_addr  <= AW'(32'(r_cy) * 32'(IMAGE_WIDTH) + 32'(r_cx));
            end
            S_MUPD: begin
                if (r_req) begin
                    r_rstat <= STATUS_READ;
                    r_rdep  <= mem_rdata;
                end else if (upd_write) begin
                    r_rstat <= STATUS_WRITTEN;
                    r_rdep  <= r_z[DEPTH_W-1:0];
                end else begin
                    r_rstat <= STATUS_KEPT;
                    r_rdep  <= mem_rdata;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/pdp_cfg.sv =====
// Configuration register file with its APB-style port.
`timescale 1ns / 1ps
module pdp_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output pdp_pkg::t_cfg  o_cfg
);
    import pdp_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x       <= 31'd34406400;
            r_cfg.focal_y       <= 31'd34406400;
            r_cfg.center_x      <= 32'sd20938752;
            r_cfg.center_y      <= 32'sd15695872;
            r_cfg.min_depth     <= 31'd6554;
            r_cfg.max_depth     <= RESET_MAX_DEPTH;
            r_cfg.active_width  <= 10'd640;
            r_cfg.active_height <= 9'd480;
        end else if (wr) begin
            unique case (idx)
                REG_FOCAL_X:  r_cfg.focal_x       <= pwdata[30:0];
                REG_FOCAL_Y:  r_cfg.focal_y       <= pwdata[30:0];
                REG_CENTER_X: r_cfg.center_x      <= pwdata;
                REG_CENTER_Y: r_cfg.center_y      <= pwdata;
                REG_MIN_D:    r_cfg.min_depth     <= pwdata[30:0];
                REG_MAX_D:    r_cfg.max_depth     <= pwdata[30:0];
                REG_ACT_W:    r_cfg.active_width  <= pwdata[9:0];
                REG_ACT_H:    r_cfg.active_height <= pwdata[8:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FOCAL_X:  prdata = {1'b0, r_cfg.focal_x};
            REG_FOCAL_Y:  prdata = {1'b0, r_cfg.focal_y};
            REG_CENTER_X: prdata = r_cfg.center_x;
            REG_CENTER_Y: prdata = r_cfg.center_y;
            REG_MIN_D:    prdata = {1'b0, r_cfg.min_depth};
            REG_MAX_D:    prdata = {1'b0, r_cfg.max_depth};
            REG_ACT_W:    prdata = {22'd0, r_cfg.active_width};
            REG_ACT_H:    prdata = {23'd0, r_cfg.active_height};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/pdp_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pdp_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pdp_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [pdp_pkg::DEPTH_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [pdp_pkg::DIVD_W-1:0]   o_quotient
);
    import pdp_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DEPTH_W-1:0]  r_rem;
    logic [DIVD_W-1:0]   r_quo;
    logic [DEPTH_W-1:0]  r_dvs;
    logic [DEPTH_W:0]    trial;
    logic                fits;

    assign trial      = {r_rem, r_quo[DIVD_W-1]};
    assign fits       = trial >= {1'b0, r_dvs};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits DEPTH_W bits
            r_rem <= fits ? DEPTH_W'(trial - {1'b0, r_dvs}) : trial[DEPTH_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

endmodule

// ===== design/pdp_depth_mem.sv =====
// Depth image store: one write port, one registered read port.
`timescale 1ns / 1ps
module pdp_depth_mem #(
    parameter int unsigned ENTRIES = 307200,
    parameter int unsigned AW      = 19
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [pdp_pkg::DEPTH_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [pdp_pkg::DEPTH_W-1:0]  o_rdata
);
    import pdp_pkg::*;

    logic [DEPTH_W-1:0] mem [ENTRIES];
    logic [DEPTH_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

endmodule
